FILE: sv/sliding_window_avg_min_max_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window unit
// Shared helpers so every check uses the same clock and reset qualification.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVG_MIN_MAX_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_AVG_MIN_MAX_UNIT_DEFINES_SVH

// same-cycle implication, checked on i_clk, off during reset
`define SWAMM_ASSERT_IMPL(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWAMM_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

FILE: sv/swamm_pkg.sv
// ----------------------------------------------------------------------------
// swamm_pkg
// Widths, register map, state codes and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package swamm_pkg;

    localparam int WINDOW_MAX_DEF = 256;
    localparam int SAMPLE_W       = 16;
    localparam int SUM_W          = 24;
    localparam int LEN_W          = 9;
    localparam int MEAN_FRAC      = 8;
    localparam int DIVD_W         = SUM_W + MEAN_FRAC;
    localparam int APB_DW         = 32;
    localparam int PADDR_W        = 3;
    localparam int REG_IDX_W      = PADDR_W - 2;

    localparam logic [LEN_W-1:0]     LEN_RESET         = 9'd4;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'd0;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PREP = 5'b00010,
        ST_RD   = 5'b00100,
        ST_SCAN = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
    } t_div_ctrl;

    typedef struct packed {
        logic              busy;
        logic [DIVD_W-1:0] quotient;
    } t_div_stat;

endpackage

`default_nettype wire

FILE: sv/swamm_ifs.sv
// ----------------------------------------------------------------------------
// swamm stream interfaces
// Valid/ready channels for input samples and window results.
// ----------------------------------------------------------------------------
`default_nettype none

interface swamm_in_if;
    import swamm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_of_sequence;

    modport source (output valid, sample, start_of_sequence, input ready);
    modport sink   (input valid, sample, start_of_sequence, output ready);
endinterface

interface swamm_out_if;
    import swamm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SUM_W-1:0]    window_sum;
    logic signed [SUM_W-1:0]    window_mean_q8;
    logic signed [SAMPLE_W-1:0] window_max;
    logic signed [SAMPLE_W-1:0] window_min;

    modport source (output valid, window_sum, window_mean_q8, window_max, window_min,
                    input ready);
    modport sink   (input valid, window_sum, window_mean_q8, window_max, window_min,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/swamm_store.sv
// ----------------------------------------------------------------------------
// swamm_store
// Sample ring memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module swamm_store #(
    parameter int DEPTH = swamm_pkg::WINDOW_MAX_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [AW-1:0]                        i_waddr,
    input  wire logic signed [swamm_pkg::SAMPLE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                        i_raddr,
    output logic signed [swamm_pkg::SAMPLE_W-1:0]     o_rdata
);
    import swamm_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/swamm_div.sv
// ----------------------------------------------------------------------------
// swamm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swamm_div #(
    parameter int DVS_W = 9
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire swamm_pkg::t_div_ctrl  i_ctrl,
    input  wire logic [DVS_W-1:0]      i_divisor,
    output swamm_pkg::t_div_stat       o_stat
);
    import swamm_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    trial;
    logic              ge;
    logic [DVS_W:0]    diff;

    // shift the next dividend bit into the partial remainder
    assign trial = {r_rem, r_quo[DIVD_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIVD_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_quo <= i_ctrl.dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.quotient = r_quo;

endmodule

`default_nettype wire

FILE: sv/sliding_window_avg_min_max_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_avg_min_max_unit
// Windowed sum, Q.8 mean, maximum and minimum over signed 16-bit samples.
// ----------------------------------------------------------------------------
// One sample is taken at a time; the input is ready again once the previous
// sample has been fully processed. While the window fills, a sample passes
// through the PREP and RD states and yields no result. Once the window holds
// window_length samples (L), each sample's result is registered in the output
// register after the 32-step serial divider that forms the mean has finished,
// and the next sample can then be taken. When the leaving sample was the
// current minimum or maximum, the single read port of the sample memory walks
// all L entries before the result is registered (the divide runs alongside).
// A finished result waits in the output register while the next sample is
// taken; a sample cannot finish while that register is still held by the
// receiver. Writing window_length (byte address 0) or a sample with
// start_of_sequence set clears the window; lengths of 0 act as 1 and lengths
// above WINDOW_MAX act as WINDOW_MAX.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_avg_min_max_unit_defines.svh"

module sliding_window_avg_min_max_unit #(
    parameter int WINDOW_MAX = swamm_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [swamm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [swamm_pkg::APB_DW-1:0]  pwdata,
    output logic [swamm_pkg::APB_DW-1:0]       prdata,
    output logic                               pready,
    swamm_in_if.sink                           i_in,
    swamm_out_if.source                        o_out
);
    import swamm_pkg::*;

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int NW = $clog2(WINDOW_MAX + 1);
    localparam int CW = (NW > LEN_W) ? NW : LEN_W;

    // registers
    t_state                     r_state, n_state;
    logic [LEN_W-1:0]           r_len, n_len;
    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic                       r_sos, n_sos;
    logic [AW-1:0]              r_wp, n_wp;
    logic [NW-1:0]              r_fill, n_fill;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic signed [SAMPLE_W-1:0] r_min, n_min;
    logic signed [SAMPLE_W-1:0] r_max, n_max;
    logic                       r_resc_min, n_resc_min;
    logic                       r_resc_max, n_resc_max;
    logic [NW-1:0]              r_scan_idx, n_scan_idx;
    logic                       r_rd_vld, n_rd_vld;
    logic                       r_rd_last, n_rd_last;
    logic                       r_first, n_first;
    logic signed [SAMPLE_W-1:0] r_best_min, n_best_min;
    logic signed [SAMPLE_W-1:0] r_best_max, n_best_max;
    logic                       r_sum_neg, n_sum_neg;
    logic                       r_out_vld, n_out_vld;
    logic signed [SUM_W-1:0]    r_out_sum, n_out_sum;
    logic signed [SUM_W-1:0]    r_out_mean, n_out_mean;
    logic signed [SAMPLE_W-1:0] r_out_max, n_out_max;
    logic signed [SAMPLE_W-1:0] r_out_min, n_out_min;

    // combinational
    logic                       in_fire;
    logic                       cfg_wr;
    logic [CW-1:0]              len_ext;
    logic [NW-1:0]              eff_n;
    logic [AW-1:0]              wp_eff;
    logic [NW-1:0]              wp_inc;
    logic                       has_res;
    logic [SUM_W-1:0]           sum_abs;
    logic [DIVD_W-1:0]          q_neg;
    logic signed [SAMPLE_W-1:0] old_s;
    logic                       mem_we;
    logic [AW-1:0]              mem_raddr;
    logic signed [SAMPLE_W-1:0] mem_rdata;
    t_div_ctrl                  div_ctrl;
    t_div_stat                  div_stat;

    assign in_fire = i_in.valid && i_in.ready;
    assign cfg_wr  = psel && penable && pwrite
                     && (paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH);

    // effective window length, clamped to 1..WINDOW_MAX
    assign len_ext = CW'(r_len);
    always_comb begin
        if (r_len == '0) begin
            eff_n = NW'(1);
        end else if (len_ext > CW'(WINDOW_MAX)) begin
            eff_n = NW'(WINDOW_MAX);
        end else begin
            eff_n = NW'(len_ext);
        end
    end

    assign wp_eff = (r_sos || (NW'(r_wp) >= eff_n)) ? '0 : r_wp;
    assign wp_inc = NW'(r_wp) + 1'b1;
    assign old_s  = mem_rdata;
    assign q_neg  = -div_stat.quotient;

    assign mem_we    = (r_state == ST_RD);
    assign mem_raddr = (r_state == ST_PREP) ? wp_eff : r_scan_idx[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_sample   = r_sample;
        n_sos      = r_sos;
        n_wp       = r_wp;
        n_fill     = r_fill;
        n_sum      = r_sum;
        n_min      = r_min;
        n_max      = r_max;
        n_resc_min = r_resc_min;
        n_resc_max = r_resc_max;
        n_scan_idx = r_scan_idx;
        n_rd_vld   = 1'b0;
        n_rd_last  = 1'b0;
        n_first    = r_first;
        n_best_min = r_best_min;
        n_best_max = r_best_max;
        n_sum_neg  = r_sum_neg;
        n_out_vld  = r_out_vld && !o_out.ready;
        n_out_sum  = r_out_sum;
        n_out_mean = r_out_mean;
        n_out_max  = r_out_max;
        n_out_min  = r_out_min;
        has_res    = 1'b0;
        sum_abs    = '0;
        div_ctrl   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_sample = i_in.sample;
                    n_sos    = i_in.start_of_sequence;
                    n_state  = ST_PREP;
                end
            end
            ST_PREP: begin
                // apply start-of-sequence clear, fetch the leaving sample
                if (r_sos) begin
                    n_fill = '0;
                    n_sum  = '0;
                    n_min  = '0;
                    n_max  = '0;
                end
                n_wp    = wp_eff;
                n_state = ST_RD;
            end
            ST_RD: begin
                n_resc_min = 1'b0;
                n_resc_max = 1'b0;
                if (r_fill < eff_n) begin
                    n_sum  = r_sum + SUM_W'(r_sample);
                    n_fill = r_fill + 1'b1;
                    if (r_fill == '0) begin
                        n_min = r_sample;
                        n_max = r_sample;
                    end else begin
                        if (r_sample < r_min) n_min = r_sample;
                        if (r_sample > r_max) n_max = r_sample;
                    end
                    has_res = (n_fill == eff_n);
                end else begin
                    n_sum = r_sum - SUM_W'(old_s) + SUM_W'(r_sample);
                    if (old_s == r_min) begin
                        n_resc_min = 1'b1;
                    end else if (r_sample < r_min) begin
                        n_min = r_sample;
                    end
                    if (old_s == r_max) begin
                        n_resc_max = 1'b1;
                    end else if (r_sample > r_max) begin
                        n_max = r_sample;
                    end
                    has_res = 1'b1;
                end
                n_wp = (wp_inc >= eff_n) ? '0 : wp_inc[AW-1:0];

                sum_abs           = n_sum[SUM_W-1] ? -n_sum : n_sum;
                n_sum_neg         = n_sum[SUM_W-1];
                div_ctrl.start    = has_res;
                div_ctrl.dividend = {sum_abs, {MEAN_FRAC{1'b0}}};

                n_scan_idx = '0;
                n_first    = 1'b1;
                if (!has_res) begin
                    n_state = ST_IDLE;
                end else if (n_resc_min || n_resc_max) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_SCAN: begin
                // one read per cycle, the registered read data compared in the next cycle
                if (r_scan_idx < eff_n) begin
                    n_scan_idx = r_scan_idx + 1'b1;
                    n_rd_vld   = 1'b1;
                    n_rd_last  = (n_scan_idx == eff_n);
                end
                if (r_rd_vld) begin
                    n_first = 1'b0;
                    if (r_first) begin
                        n_best_min = mem_rdata;
                        n_best_max = mem_rdata;
                    end else begin
                        if (mem_rdata < r_best_min) n_best_min = mem_rdata;
                        if (mem_rdata > r_best_max) n_best_max = mem_rdata;
                    end
                    if (r_rd_last) begin
                        if (r_resc_min) n_min = n_best_min;
                        if (r_resc_max) n_max = n_best_max;
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!div_stat.busy && (!r_out_vld || o_out.ready)) begin
                    n_out_vld  = 1'b1;
                    n_out_sum  = r_sum;
                    n_out_mean = r_sum_neg ? q_neg[SUM_W-1:0]
                                           : div_stat.quotient[SUM_W-1:0];
                    n_out_max  = r_max;
                    n_out_min  = r_min;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // a length write restarts the window
        if (cfg_wr) begin
            n_len  = pwdata[LEN_W-1:0];
            n_wp   = '0;
            n_fill = '0;
            n_sum  = '0;
            n_min  = '0;
            n_max  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_len     <= LEN_RESET;
            r_wp      <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_wp      <= n_wp;
            r_fill    <= n_fill;
            r_sum     <= n_sum;
            r_min     <= n_min;
            r_max     <= n_max;
            r_rd_vld  <= n_rd_vld;
            r_rd_last <= n_rd_last;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_sos      <= n_sos;
        r_resc_min <= n_resc_min;
        r_resc_max <= n_resc_max;
        r_scan_idx <= n_scan_idx;
        r_first    <= n_first;
        r_best_min <= n_best_min;
        r_best_max <= n_best_max;
        r_sum_neg  <= n_sum_neg;
        r_out_sum  <= n_out_sum;
        r_out_mean <= n_out_mean;
        r_out_max  <= n_out_max;
        r_out_min  <= n_out_min;
    end

    swamm_store #(
        .DEPTH (WINDOW_MAX),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wp),
        .i_wdata (r_sample),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    swamm_div #(
        .DVS_W (NW)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (div_ctrl),
        .i_divisor (eff_n),
        .o_stat    (div_stat)
    );

    assign i_in.ready           = (r_state == ST_IDLE);
    assign o_out.valid          = r_out_vld;
    assign o_out.window_sum     = r_out_sum;
    assign o_out.window_mean_q8 = r_out_mean;
    assign o_out.window_max     = r_out_max;
    assign o_out.window_min     = r_out_min;

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == REG_WINDOW_LENGTH) ? APB_DW'(r_len) : '0;

    `SWAMM_ASSERT_IMPL(a_min_le_max, (r_state == ST_IDLE) && (r_fill != '0), r_min <= r_max, "window min above max")
    `SWAMM_ASSERT_IMPL(a_wp_in_window, r_state == ST_IDLE, NW'(r_wp) < eff_n, "write pointer outside window")
    `SWAMM_ASSERT_IMPL(a_div_idle_on_accept, in_fire, !div_stat.busy, "sample taken while divide pending")
    `SWAMM_ASSERT_NEXT(a_div_runs_for_result, (r_state == ST_RD) && has_res, div_stat.busy, "result without divide")

endmodule

`default_nettype wire
